// File: rtl/pds_pkg.sv
package pds_pkg;

   localparam int PRIME_COUNT = 65536;
   localparam int IDX_W = $clog2(PRIME_COUNT);
   localparam int CNT_W = IDX_W + 1;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [15:0] table_index;
      logic [31:0] prime_value;
      logic [63:0] number;
   } req_type_type;

   typedef struct packed {
      logic [63:0] divisor_sum;
      logic [63:0] number_echo;
   } rsp_type;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
      logic [31:0] remainder;
   } div_rsp_type;

endpackage

// File: rtl/pds_divider.sv
module pds_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  pds_pkg::div_req_type div_req,
   output pds_pkg::div_rsp_type div_rsp
);
   import pds_pkg::*;

   // restoring divider, one quotient bit per cycle
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[63]};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff[31:0];

endmodule

// File: rtl/pds_multiplier.sv
module pds_multiplier (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);
   import pds_pkg::*;

   // 64x64 low product from three 32x32 partials, one per cycle
   logic [63:0] acc_ff, acc_in;
   logic [63:0] a_ff, a_in, b_ff, b_in;
   logic [2:0]  ph_ff, ph_in;
   logic        done_ff, done_in;
   logic [31:0] ma, mb;
   logic [63:0] part;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      ph_in   = ph_ff;
      done_in = 1'b0;
      ma      = a_ff[31:0];
      mb      = b_ff[31:0];
      unique case (ph_ff)
         3'd2:    begin ma = a_ff[31:0];  mb = b_ff[63:32]; end
         3'd3:    begin ma = a_ff[63:32]; mb = b_ff[31:0];  end
         default: begin ma = a_ff[31:0];  mb = b_ff[31:0];  end
      endcase
      part = {32'd0, ma} * {32'd0, mb};
      if (start) begin
         a_in   = op_a;
         b_in   = op_b;
         acc_in = '0;
         ph_in  = 3'd1;
      end else begin
         unique case (ph_ff)
            3'd1: begin acc_in = part; ph_in = 3'd2; end
            3'd2: begin acc_in = acc_ff + {part[31:0], 32'd0}; ph_in = 3'd3; end
            3'd3: begin
               acc_in  = acc_ff + {part[31:0], 32'd0};
               ph_in   = 3'd0;
               done_in = 1'b1;
            end
            default: ph_in = 3'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: rtl/proper_divisor_sum.sv
// Sum of proper divisors of a 64-bit number by trial division over an internal
// table of up to 65536 32-bit primes. A load transfer (req_type 0) writes one entry
// at its accepting edge and leaves the block ready for the next transfer in the
// following cycle. A query transfer tries the table primes in turn, each by a 64-bit
// division (a bit-serial divider is the shared unit, run once per candidate prime
// and once per extra power found), with 64-bit multiplies building the powers and
// the product of sums. busy is high while a query is at work and during its result
// cycle. Each query's result appears on rsp_* for exactly one cycle with rsp_valid
// high; the receiver cannot stall and must take it then.
// Write the register (csr_we) only while idle.
module proper_divisor_sum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pds_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   output pds_pkg::rsp_type      rsp_data,
   input  logic                  csr_we,
   input  logic [16:0]           csr_wdata
);
   import pds_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;
   localparam logic [3:0] S_CHK   = 4'd2;
   localparam logic [3:0] S_SQ    = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_PMUL  = 4'd5;
   localparam logic [3:0] S_TMUL  = 4'd6;
   localparam logic [3:0] S_FIN   = 4'd7;
   localparam logic [3:0] S_FMUL  = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;
   localparam logic [3:0] S_RDW   = 4'd10;

   logic [31:0] prime_mem [PRIME_COUNT];
   logic [31:0] rd_ff;

   logic [3:0]       st_ff, st_in;
   logic [CNT_W-1:0] piu_ff;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [63:0]      n_ff, n_in, rest_ff, rest_in, prod_ff, prod_in;
   logic [63:0]      pow_ff, pow_in, term_ff, term_in;
   logic [31:0]      p_ff, p_in;
   logic             found_ff, found_in;
   logic             sq_ff, sq_in;
   logic             vld_ff, vld_in;
   logic [63:0]      sum_ff, sum_in;

   div_req_type dq;
   div_rsp_type dr;
   logic        m_start, m_done;
   logic [63:0] m_a, m_b, m_p;
   logic [CNT_W-1:0] limit;
   logic [63:0] psq;
   logic        accept;

   pds_divider u_div (.clock(clock), .reset(reset), .div_req(dq), .div_rsp(dr));
   pds_multiplier u_mul (.clock(clock), .reset(reset), .start(m_start),
      .op_a(m_a), .op_b(m_b), .done(m_done), .product(m_p));

   assign limit  = (piu_ff > CNT_W'(PRIME_COUNT)) ? CNT_W'(PRIME_COUNT) : piu_ff;
   assign psq    = {32'd0, p_ff} * {32'd0, p_ff};
   assign accept = start && !busy;

   // table write on load, registered read during walk
   always_ff @(posedge clock) begin
      if (accept && req_data.req_type == REQ_LOAD) begin
         prime_mem[req_data.table_index] <= req_data.prime_value;
      end
      rd_ff <= prime_mem[idx_ff[IDX_W-1:0]];
   end

   always_comb begin
      st_in    = st_ff;
      idx_in   = idx_ff;
      n_in     = n_ff;
      rest_in  = rest_ff;
      prod_in  = prod_ff;
      pow_in   = pow_ff;
      term_in  = term_ff;
      p_in     = p_ff;
      found_in = found_ff;
      sq_in    = sq_ff;
      vld_in   = 1'b0;
      sum_in   = sum_ff;
      dq       = '0;
      m_start  = 1'b0;
      m_a      = pow_ff;
      m_b      = {32'd0, p_ff};
      unique case (st_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.req_type == REQ_LOAD) begin
                  st_in = S_IDLE;
               end else begin
                  n_in    = req_data.number;
                  rest_in = req_data.number;
                  prod_in = 64'd1;
                  idx_in  = '0;
                  st_in   = (req_data.number < 64'd2) ? S_OUT : S_RD;
                  sum_in  = 64'd0;
               end
            end
         end
         S_RD: begin
            // index presented, wait for registered read
            if (idx_ff >= limit) st_in = S_FIN;
            else st_in = S_RDW;
         end
         S_RDW: begin
            p_in  = rd_ff;
            st_in = S_SQ;
         end
         S_SQ: begin
            sq_in = psq > rest_ff;
            st_in = S_CHK;
         end
         S_CHK: begin
            if (p_ff < 32'd2) begin
               idx_in = idx_ff + CNT_W'(1);
               st_in  = S_RD;
            end else if (sq_ff) begin
               st_in = S_FIN;
            end else begin
               dq.start    = 1'b1;
               dq.dividend = rest_ff;
               dq.divisor  = p_ff;
               found_in    = 1'b0;
               pow_in      = 64'd1;
               term_in     = 64'd1;
               st_in       = S_DIV;
            end
         end
         S_DIV: begin
            if (dr.done) begin
               if (dr.remainder == 32'd0) begin
                  rest_in  = dr.quotient;
                  found_in = 1'b1;
                  m_start  = 1'b1;
                  st_in    = S_PMUL;
               end else if (found_ff) begin
                  m_start = 1'b1;
                  m_a     = prod_ff;
                  m_b     = term_ff;
                  st_in   = S_TMUL;
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
                  st_in  = S_RD;
               end
            end
         end
         S_PMUL: begin
            if (m_done) begin
               pow_in      = m_p;
               term_in     = term_ff + m_p;
               dq.start    = 1'b1;
               dq.dividend = rest_ff;
               dq.divisor  = p_ff;
               st_in       = S_DIV;
            end
         end
         S_TMUL: begin
            if (m_done) begin
               prod_in = m_p;
               idx_in  = idx_ff + CNT_W'(1);
               st_in   = S_RD;
            end
         end
         S_FIN: begin
            if (rest_ff > 64'd1) begin
               m_start = 1'b1;
               m_a     = prod_ff;
               m_b     = rest_ff + 64'd1;
               st_in   = S_FMUL;
            end else begin
               sum_in = prod_ff - n_ff;
               st_in  = S_OUT;
            end
         end
         S_FMUL: begin
            if (m_done) begin
               sum_in = m_p - n_ff;
               st_in  = S_OUT;
            end
         end
         S_OUT: begin
            vld_in = 1'b1;
            st_in  = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         piu_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         vld_ff <= vld_in;
         if (csr_we) piu_ff <= csr_wdata;
      end
      idx_ff   <= idx_in;
      n_ff     <= n_in;
      rest_ff  <= rest_in;
      prod_ff  <= prod_in;
      pow_ff   <= pow_in;
      term_ff  <= term_in;
      p_ff     <= p_in;
      found_ff <= found_in;
      sq_ff    <= sq_in;
      sum_ff   <= sum_in;
   end

   assign busy                 = (st_ff != S_IDLE) || vld_ff;
   assign rsp_valid            = vld_ff;
   assign rsp_data.divisor_sum = sum_ff;
   assign rsp_data.number_echo = n_ff;

endmodule

// File: tb/tb_proper_divisor_sum.sv
`timescale 1ns / 1ps

module tb_proper_divisor_sum;
   import pds_pkg::*;

   localparam int NUM_SMALL = 48;
   localparam int STALL_LIMIT = 200000;
   localparam logic [31:0] SMALL_PRIMES [NUM_SMALL] = '{
      2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53,
      59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127, 131,
      137, 139, 149, 151, 157, 163, 167, 173, 179, 181, 191, 193, 197, 199, 211, 223};

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_type_type req_data;
   logic         rsp_valid;
   rsp_type      rsp_data;
   logic         csr_we;
   logic [16:0]  csr_wdata;

   // local copy of the block state
   logic [31:0]  shadow_table [PRIME_COUNT];
   logic [16:0]  shadow_in_use;
   rsp_type      pending_sums [$];

   int  error_count;
   int  queries_sent;
   int  loads_sent;
   int  sums_checked;
   int  stall_cycles;
   bit  gaps_on;

   proper_divisor_sum dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // sigma(n) - n by trial division over the shadow table, wrapping at 64 bits
   function automatic logic [63:0] proper_sum(input logic [63:0] n);
      logic [63:0] product;
      logic [63:0] rest;
      logic [63:0] p;
      logic [63:0] term;
      logic [63:0] power;
      int          limit;
      product = 64'd1;
      rest = n;
      if (n < 64'd2) return 64'd0;
      limit = (shadow_in_use > PRIME_COUNT) ? PRIME_COUNT : int'(shadow_in_use);
      for (int i = 0; i < limit; i++) begin
         p = {32'd0, shadow_table[i]};
         if (p < 64'd2) continue;
         if (p * p > rest) break;
         if (rest % p == 64'd0) begin
            term = 64'd1;
            power = 64'd1;
            do begin
               rest = rest / p;
               power = power * p;
               term = term + power;
            end while (rest % p == 64'd0);
            product = product * term;
         end
      end
      if (rest > 64'd1) product = product * (rest + 64'd1);
      return product - n;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // one transfer on the request side; the model is updated at acceptance
   task automatic send_item(input req_type_type item);
      rsp_type exp_sum;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      if (item.req_type == REQ_LOAD) begin
         shadow_table[item.table_index] = item.prime_value;
         loads_sent++;
      end else begin
         exp_sum.divisor_sum = proper_sum(item.number);
         exp_sum.number_echo = item.number;
         pending_sums = {pending_sums, exp_sum};
         queries_sent++;
      end
   endtask

   task automatic load_entry(input logic [15:0] idx, input logic [31:0] val);
      req_type_type item;
      item.req_type = REQ_LOAD;
      item.table_index = idx;
      item.prime_value = val;
      item.number = {$urandom, $urandom};
      send_item(item);
   endtask

   task automatic query(input logic [63:0] n);
      req_type_type item;
      item.req_type = REQ_QUERY;
      item.table_index = 16'($urandom);
      item.prime_value = $urandom;
      item.number = n;
      send_item(item);
   endtask

   // wait for all results and the block to go quiet, then write the register
   task automatic set_in_use(input logic [16:0] value);
      start <= 1'b0;
      do @(posedge clock); while (pending_sums.size() != 0 || busy);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_in_use = value;
   endtask

   // product of a few table primes, so the walk finds real factors
   function automatic logic [63:0] smooth_number();
      logic [63:0] n;
      n = 64'd1;
      repeat ($urandom_range(1, 8))
         n = n * SMALL_PRIMES[$urandom_range(0, NUM_SMALL - 1)];
      return n;
   endfunction

   // empty table: every number above one comes back as if prime
   task automatic test_empty_table();
      query(64'd0);
      query(64'd1);
      query(64'd2);
      query('1);
   endtask

   task automatic test_fill_table();
      foreach (SMALL_PRIMES[i]) load_entry(16'(i), SMALL_PRIMES[i]);
      load_entry(16'hFFFF, 32'hFFFF_FFFF);
      set_in_use(17'(NUM_SMALL));
   endtask

   task automatic test_known_sums();
      query(64'd28);                      // perfect number
      query(64'd12);
      query(64'h8000_0000_0000_0000);      // power sum fills all 64 bits
      query(64'd12157665459056928801);     // 3^40
      query(64'd51983);                   // table runs out on a composite
      query(64'hFFFF_FFFF_FFFF_FFFF);
      query(64'hFFFF_FFF6_0000_0019);      // square of a large prime
   endtask

   // entries 0 and 1 are skipped, 9 is not prime but still used
   task automatic test_odd_entries();
      load_entry(16'd0, 32'd0);
      load_entry(16'd1, 32'd1);
      load_entry(16'd3, 32'd9);
      query(64'd5040);
      query(64'd1125);
      load_entry(16'd0, 32'd2);
      load_entry(16'd1, 32'd3);
      load_entry(16'd3, 32'd7);
   endtask

   // numbers below 223^2 stop the walk inside the written entries
   task automatic test_register_extremes();
      set_in_use(17'd0);
      query(64'd30);
      set_in_use(17'(PRIME_COUNT));
      query(64'd49728);
      query(64'd223 * 64'd211);
      set_in_use(17'h1FFFF);
      query(64'd720);
      set_in_use(17'd1);
      query(64'd96);
   endtask

   task automatic test_random_mix();
      for (int phase = 0; phase < 4; phase++) begin
         set_in_use(17'($urandom_range(0, NUM_SMALL)));
         if (phase == 3) gaps_on = 1'b0;
         else gaps_on = $urandom_range(0, 4) != 0;
         repeat (17) begin
            case ($urandom_range(0, 9))
               0, 1, 2: query(smooth_number());
               3: query(64'($urandom_range(0, 60000)));
               4, 5: query({$urandom, $urandom});
               6: load_entry(16'($urandom_range(0, NUM_SMALL - 1)),
                             SMALL_PRIMES[$urandom_range(0, NUM_SMALL - 1)]);
               7: load_entry(16'($urandom_range(0, NUM_SMALL - 1)),
                             $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1));
               default: load_entry(16'($urandom_range(NUM_SMALL, 65535)), $urandom);
            endcase
         end
      end
   endtask

   // result side: each strobe is one transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_sums.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.number_echo, 64'd0);
         end else begin
            if (rsp_data.divisor_sum !== pending_sums[0].divisor_sum)
               report_mismatch("divisor_sum", rsp_data.divisor_sum,
                               pending_sums[0].divisor_sum);
            if (rsp_data.number_echo !== pending_sums[0].number_echo)
               report_mismatch("number_echo", rsp_data.number_echo,
                               pending_sums[0].number_echo);
            void'(pending_sums.pop_front());
            sums_checked++;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || csr_we) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      error_count = 0;
      queries_sent = 0;
      loads_sent = 0;
      sums_checked = 0;
      stall_cycles = 0;
      gaps_on = 1'b1;
      shadow_in_use = '0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_fill_table();
      test_known_sums();
      test_odd_entries();
      test_register_extremes();
      test_random_mix();

      start <= 1'b0;
      do @(posedge clock); while (pending_sums.size() != 0 || busy);
      repeat (20) @(posedge clock);

      $display("covered %0d queries and %0d table loads, %0d sums checked",
               queries_sent, loads_sent, sums_checked);
      $display("register settings from zero to the 17-bit maximum, %0d mismatches",
               error_count);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
